[rtl/core/icy_metadata_deinterleaver_top_assert.svh]
// Assertion macros for the ICY metadata deinterleaver top level
`ifndef ICY_METADATA_DEINTERLEAVER_TOP_ASSERT_SVH
`define ICY_METADATA_DEINTERLEAVER_TOP_ASSERT_SVH

// same-cycle implication, checked on every rising edge outside reset
`define ICY_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("icy deinterleaver check failed");

// next-cycle implication
`define ICY_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("icy deinterleaver check failed");

`endif

[rtl/core/imd_pkg.sv]
// Shared types and constants for the ICY metadata deinterleaver
`default_nettype none
package imd_pkg;

  localparam int BYTE_W      = 8;
  localparam int INTERVAL_W  = 20;
  localparam int LEN_W       = 12;
  localparam int BLOCK_LOG2  = 4;
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [1:0] {
    KIND_AUDIO  = 2'd0,
    KIND_LENGTH = 2'd1,
    KIND_TEXT   = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    PH_AUDIO  = 2'd0,
    PH_LENGTH = 2'd1,
    PH_TEXT   = 2'd2
  } phase_t;

  typedef struct packed {
    logic [BYTE_W-1:0] out_byte;
    kind_t             byte_kind;
    logic              section_end;
    logic [LEN_W-1:0]  text_length;
  } res_t;

  typedef struct packed {
    logic not_empty;
    logic full;
  } q_stat_t;

endpackage
`default_nettype wire

[rtl/core/imd_front.sv]
// Front end: byte acceptance and audio/length/text classification
`default_nettype none
module imd_front #(
  parameter int MAX_META_BLOCKS = 255
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_write,
  input  logic [imd_pkg::INTERVAL_W-1:0] cfg_data,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [imd_pkg::BYTE_W-1:0]     data_byte,
  input  imd_pkg::q_stat_t               q_stat,
  output logic                           push,
  output imd_pkg::res_t                  res
);
  import imd_pkg::*;

  logic [INTERVAL_W-1:0] meta_interval;
  logic [INTERVAL_W-1:0] audio_left, audio_left_next;
  phase_t                phase, phase_next;
  logic [LEN_W-1:0]      meta_left, meta_left_next;
  logic [LEN_W-1:0]      meta_position, meta_position_next;
  logic [LEN_W-1:0]      last_nonzero_end, last_nonzero_end_next;

  logic                  enabled;
  logic [BYTE_W-1:0]     blocks;
  logic [LEN_W-1:0]      section_len;
  logic [LEN_W-1:0]      pos_inc;
  logic [LEN_W-1:0]      left_dec;
  logic [LEN_W-1:0]      lnz_upd;
  logic [INTERVAL_W-1:0] audio_base;
  logic [INTERVAL_W-1:0] audio_dec;

  assign in_ready = !q_stat.full;
  assign push     = in_valid && in_ready;
  assign enabled  = (meta_interval != '0);

  assign blocks      = (data_byte > BYTE_W'(MAX_META_BLOCKS)) ? BYTE_W'(MAX_META_BLOCKS)
                                                              : data_byte;
  assign section_len = {blocks, {BLOCK_LOG2{1'b0}}};
  assign pos_inc     = meta_position + LEN_W'(1);
  assign left_dec    = meta_left - LEN_W'(1);
  assign lnz_upd     = (data_byte != '0) ? pos_inc : last_nonzero_end;
  assign audio_base  = (audio_left == '0) ? meta_interval : audio_left;
  assign audio_dec   = audio_base - INTERVAL_W'(1);

  // next state
  always_comb begin
    phase_next = phase;
    if (push && enabled) begin
      case (phase)
        PH_LENGTH: phase_next = (section_len == '0) ? PH_AUDIO : PH_TEXT;
        PH_TEXT:   phase_next = (left_dec == '0) ? PH_AUDIO : PH_TEXT;
        default:   phase_next = (audio_dec == '0) ? PH_LENGTH : PH_AUDIO;
      endcase
    end
  end

  // counters and result
  always_comb begin
    audio_left_next       = audio_left;
    meta_left_next        = meta_left;
    meta_position_next    = meta_position;
    last_nonzero_end_next = last_nonzero_end;
    res.out_byte          = data_byte;
    res.byte_kind         = KIND_AUDIO;
    res.section_end       = 1'b0;
    res.text_length       = '0;
    if (enabled) begin
      case (phase)
        PH_LENGTH: begin
          res.byte_kind         = KIND_LENGTH;
          meta_left_next        = section_len;
          meta_position_next    = '0;
          last_nonzero_end_next = '0;
          if (section_len == '0) begin
            res.section_end = 1'b1;
            audio_left_next = meta_interval;
          end
        end
        PH_TEXT: begin
          res.byte_kind         = KIND_TEXT;
          meta_left_next        = left_dec;
          meta_position_next    = pos_inc;
          last_nonzero_end_next = lnz_upd;
          if (left_dec == '0) begin
            res.section_end       = 1'b1;
            res.text_length       = lnz_upd;
            audio_left_next       = meta_interval;
            meta_position_next    = '0;
            last_nonzero_end_next = '0;
          end
        end
        default: begin
          audio_left_next = audio_dec;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      meta_interval    <= '0;
      audio_left       <= '0;
      phase            <= PH_AUDIO;
      meta_left        <= '0;
      meta_position    <= '0;
      last_nonzero_end <= '0;
    end else if (cfg_write) begin
      meta_interval    <= cfg_data;
      audio_left       <= cfg_data;
      phase            <= PH_AUDIO;
      meta_left        <= '0;
      meta_position    <= '0;
      last_nonzero_end <= '0;
    end else if (push) begin
      audio_left       <= audio_left_next;
      phase            <= phase_next;
      meta_left        <= meta_left_next;
      meta_position    <= meta_position_next;
      last_nonzero_end <= last_nonzero_end_next;
    end
  end

endmodule
`default_nettype wire

[rtl/core/imd_queue.sv]
// Short result queue between front and back ends
`default_nettype none
module imd_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  imd_pkg::res_t     push_res,
  input  logic              pop,
  output imd_pkg::res_t     head,
  output imd_pkg::q_stat_t  q_stat
);
  import imd_pkg::*;

  res_t              entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;

  assign head             = entries[rd_ptr];
  assign q_stat.not_empty = (count != '0);
  assign q_stat.full      = (count == QCNT_W'(QUEUE_DEPTH));

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_res;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + QPTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + QCNT_W'(1);
      end else if (pop && !push) begin
        count <= count - QCNT_W'(1);
      end
    end
  end

endmodule
`default_nettype wire

[rtl/core/imd_back.sv]
// Back end: output register feeding the result channel
`default_nettype none
module imd_back (
  input  logic             clk,
  input  logic             rst,
  input  imd_pkg::q_stat_t q_stat,
  input  imd_pkg::res_t    head,
  output logic             pop,
  output logic             out_valid,
  input  logic             out_ready,
  output imd_pkg::res_t    out_res
);
  import imd_pkg::*;

  res_t out_reg;

  assign pop     = q_stat.not_empty && (!out_valid || out_ready);
  assign out_res = out_reg;

  always_ff @(posedge clk) begin
    if (pop) begin
      out_reg <= head;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

endmodule
`default_nettype wire

[rtl/core/icy_metadata_deinterleaver_top.sv]
// Top level of the ICY metadata deinterleaver
//
// Input channel: in_valid/in_ready carry one stream byte (data_byte) per transfer.
// Output channel: out_valid/out_ready carry one tagged result per input byte:
//   out_byte (byte passed through), byte_kind (audio, length or text),
//   section_end and text_length (trailing NULs trimmed) on the closing byte.
// cfg_write/cfg_data load meta_interval and restart audio counting;
//   write it only while no bytes are in flight. Zero passes everything as audio.
// An accepted byte's result is written into the queue, then into the output register.
// Throughput: one byte per cycle sustained while the queue is not full; classification
//   is a single pass of counter updates and compares in the front end.
// A two-entry queue sits between the classifier and the output register, so
//   in_ready only drops when the queue is full, i.e. while the receiver stalls.
// Stalled results hold on the output until taken; nothing is dropped.
// Reset clears the interval to zero, the phase to audio and empties the queue.
`default_nettype none
`include "icy_metadata_deinterleaver_top_assert.svh"
module icy_metadata_deinterleaver_top #(
  parameter int MAX_META_BLOCKS = 255
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_write,
  input  logic [imd_pkg::INTERVAL_W-1:0] cfg_data,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [imd_pkg::BYTE_W-1:0]     data_byte,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [imd_pkg::BYTE_W-1:0]     out_byte,
  output logic [1:0]                     byte_kind,
  output logic                           section_end,
  output logic [imd_pkg::LEN_W-1:0]      text_length
);
  import imd_pkg::*;

  q_stat_t q_stat;
  logic    push;
  logic    pop;
  res_t    front_res;
  res_t    head;
  res_t    out_res;

  imd_front #(
    .MAX_META_BLOCKS (MAX_META_BLOCKS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .data_byte (data_byte),
    .q_stat    (q_stat),
    .push      (push),
    .res       (front_res)
  );

  imd_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_res (front_res),
    .pop      (pop),
    .head     (head),
    .q_stat   (q_stat)
  );

  imd_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_stat    (q_stat),
    .head      (head),
    .pop       (pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_res   (out_res)
  );

  assign out_byte    = out_res.out_byte;
  assign byte_kind   = out_res.byte_kind;
  assign section_end = out_res.section_end;
  assign text_length = out_res.text_length;

  `ICY_ASSERT_NOW(a_stall_only_when_out_full, !in_ready, out_valid)
  `ICY_ASSERT_NOW(a_end_not_audio, out_valid && section_end, byte_kind != KIND_AUDIO)
  `ICY_ASSERT_NOW(a_len_only_at_end, out_valid && !section_end, text_length == '0)
  `ICY_ASSERT_NOW(a_empty_section_len, out_valid && section_end && byte_kind == KIND_LENGTH,
                  text_length == '0)

endmodule
`default_nettype wire

[verif/icy_metadata_deinterleaver_top_test.sv]
// Self-checking testbench for the ICY metadata deinterleaver: directed table, then random stream
`timescale 1ns / 1ps
module icy_metadata_deinterleaver_top_test;
  import imd_pkg::*;

  localparam int MAX_BLOCKS = 255;
  localparam int CYCLE_LIMIT = 500_000;

  typedef struct {
    bit                    is_cfg;
    logic [INTERVAL_W-1:0] interval;
    logic [BYTE_W-1:0]     b;
    bit                    typed;
    res_t                  want;
  } step_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_write = 1'b0;
  logic [INTERVAL_W-1:0] cfg_data = '0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic [BYTE_W-1:0]     data_byte = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [BYTE_W-1:0]     out_byte;
  logic [1:0]            byte_kind;
  logic                  section_end;
  logic [LEN_W-1:0]      text_length;

  // predictor state
  logic [INTERVAL_W-1:0] interval_q = '0;
  logic [INTERVAL_W-1:0] audio_cnt = '0;
  phase_t                phase_q = PH_AUDIO;
  logic [LEN_W-1:0]      text_left = '0;
  logic [LEN_W-1:0]      text_pos = '0;
  logic [LEN_W-1:0]      trim_len = '0;

  step_t       stream_q[$];
  res_t        classified_q[$];
  int unsigned bytes_in = 0;
  int unsigned mismatches = 0;
  int unsigned cycles = 0;
  int unsigned burst_left = 0;
  int unsigned gap_left = 0;
  logic [15:0] ready_pat = 16'hffff;
  int unsigned pat_left = 0;
  logic        holding = 1'b0;

  icy_metadata_deinterleaver_top #(.MAX_META_BLOCKS(MAX_BLOCKS)) DUT (
    .clk(clk), .rst(rst),
    .cfg_write(cfg_write), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready), .data_byte(data_byte),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_byte(out_byte), .byte_kind(byte_kind),
    .section_end(section_end), .text_length(text_length)
  );

  always #5 clk = ~clk;

  function automatic void load_interval(logic [INTERVAL_W-1:0] v);
    interval_q = v;
    audio_cnt  = v;
    phase_q    = PH_AUDIO;
    text_left  = '0;
    text_pos   = '0;
    trim_len   = '0;
  endfunction

  function automatic res_t classify_byte(logic [BYTE_W-1:0] b);
    res_t r;
    logic [LEN_W-1:0] blocks;
    r.out_byte    = b;
    r.byte_kind   = KIND_AUDIO;
    r.section_end = 1'b0;
    r.text_length = '0;
    if (interval_q == '0) begin
      r.byte_kind = KIND_AUDIO;
    end else if (phase_q == PH_LENGTH) begin
      r.byte_kind = KIND_LENGTH;
      blocks = (b > MAX_BLOCKS) ? LEN_W'(MAX_BLOCKS) : LEN_W'(b);
      text_left = LEN_W'(blocks * 16);
      text_pos  = '0;
      trim_len  = '0;
      if (text_left == '0) begin
        r.section_end = 1'b1;
        load_interval(interval_q);
      end else begin
        phase_q = PH_TEXT;
      end
    end else if (phase_q == PH_TEXT) begin
      r.byte_kind = KIND_TEXT;
      text_pos = text_pos + LEN_W'(1);
      if (b != '0) trim_len = text_pos;
      text_left = text_left - LEN_W'(1);
      if (text_left == '0) begin
        r.section_end = 1'b1;
        r.text_length = trim_len;
        load_interval(interval_q);
      end
    end else begin
      phase_q = PH_AUDIO;
      if (audio_cnt == '0) audio_cnt = interval_q;
      audio_cnt = audio_cnt - INTERVAL_W'(1);
      if (audio_cnt == '0) phase_q = PH_LENGTH;
    end
    return r;
  endfunction

  function automatic step_t byte_row(logic [BYTE_W-1:0] b, bit typed = 1'b0,
                                     kind_t kind = KIND_AUDIO, logic fin = 1'b0,
                                     logic [LEN_W-1:0] len = '0);
    step_t s;
    s.is_cfg             = 1'b0;
    s.interval           = '0;
    s.b                  = b;
    s.typed              = typed;
    s.want.out_byte      = b;
    s.want.byte_kind     = kind;
    s.want.section_end   = fin;
    s.want.text_length   = len;
    return s;
  endfunction

  function automatic step_t cfg_row(logic [INTERVAL_W-1:0] v);
    step_t s;
    s = byte_row('0);
    s.is_cfg   = 1'b1;
    s.interval = v;
    return s;
  endfunction

  task automatic report_mismatch(string what, logic [INTERVAL_W-1:0] want,
                                 logic [INTERVAL_W-1:0] got);
    mismatches++;
    if (mismatches <= 100)
      $display("%0t: %s mismatch, expected %h got %h", $time, what, want, got);
  endtask

  task automatic wait_drained();
    while (stream_q.size() != 0 || in_valid || classified_q.size() != 0) @(posedge clk);
  endtask

  task automatic set_interval(logic [INTERVAL_W-1:0] v);
    wait_drained();
    repeat (4) @(posedge clk);
    cfg_write <= 1'b1;
    cfg_data  <= v;
    @(posedge clk);
    cfg_write <= 1'b0;
    load_interval(v);
  endtask

  // sender: bursts with random gaps, payload held until the transfer
  always @(posedge clk) begin : sender
    res_t predicted;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        predicted = classify_byte(stream_q[0].b);
        classified_q.push_back(stream_q[0].typed ? stream_q[0].want : predicted);
        void'(stream_q.pop_front());
        bytes_in++;
      end
      if (!(in_valid && !in_ready)) begin
        if (gap_left != 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (stream_q.size() != 0) begin
          in_valid  <= 1'b1;
          data_byte <= stream_q[0].b;
          if (burst_left <= 1) begin
            burst_left = $urandom_range(1, 40);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
          end else begin
            burst_left--;
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // receiver: rotating stall pattern, reloaded now and then
  always @(posedge clk) begin : receiver
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= !holding && ready_pat[0];
      if (pat_left == 0) begin
        case ($urandom_range(0, 3))
          0: ready_pat <= 16'hffff;
          1: ready_pat <= 16'($urandom) | 16'($urandom);
          default: ready_pat <= 16'($urandom);
        endcase
        pat_left <= $urandom_range(16, 96);
      end else begin
        ready_pat <= {ready_pat[0], ready_pat[15:1]};
        pat_left <= pat_left - 1;
      end
    end
  end

  // long receiver hold-off while the stream keeps coming
  initial begin : long_hold
    while (!(bytes_in >= 400 && stream_q.size() > 100)) @(posedge clk);
    holding <= 1'b1;
    repeat (400) @(posedge clk);
    holding <= 1'b0;
  end

  always @(posedge clk) begin : result_check
    res_t want;
    if (!rst && out_valid && out_ready) begin
      if (classified_q.size() == 0) begin
        report_mismatch("unexpected transfer, out_byte", '0, INTERVAL_W'(out_byte));
      end else begin
        want = classified_q.pop_front();
        if (out_byte !== want.out_byte)
          report_mismatch("out_byte", INTERVAL_W'(want.out_byte), INTERVAL_W'(out_byte));
        if (byte_kind !== want.byte_kind)
          report_mismatch("byte_kind", INTERVAL_W'(want.byte_kind), INTERVAL_W'(byte_kind));
        if (section_end !== want.section_end)
          report_mismatch("section_end", INTERVAL_W'(want.section_end),
                          INTERVAL_W'(section_end));
        if (text_length !== want.text_length)
          report_mismatch("text_length", INTERVAL_W'(want.text_length),
                          INTERVAL_W'(text_length));
      end
    end
  end

  always @(posedge clk) begin : watchdog
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  initial begin : stimulus
    step_t                 script[$];
    step_t                 batch[$];
    step_t                 s;
    logic [INTERVAL_W-1:0] intervals[7];
    int unsigned           k, p, nblk, trim;
    bit                    big;

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    script.push_back(byte_row(8'h00, 1, KIND_AUDIO));
    script.push_back(byte_row(8'hFF, 1, KIND_AUDIO));
    script.push_back(cfg_row(20'd1));
    script.push_back(byte_row(8'h80, 1, KIND_AUDIO));
    script.push_back(byte_row(8'h00, 1, KIND_LENGTH, 1'b1, 0)); // empty section
    script.push_back(byte_row(8'h7F, 1, KIND_AUDIO));
    script.push_back(byte_row(8'h01, 1, KIND_LENGTH));
    for (k = 0; k < 15; k++) script.push_back(byte_row(8'h00, 1, KIND_TEXT));
    script.push_back(byte_row(8'h00, 1, KIND_TEXT, 1'b1, 0)); // all-NUL text
    script.push_back(cfg_row(20'hFFFFF));
    script.push_back(byte_row(8'hA5));
    script.push_back(byte_row(8'h5A));
    foreach (script[i]) begin
      if (script[i].is_cfg) set_interval(script[i].interval);
      else stream_q.push_back(script[i]);
    end

    intervals[0] = 20'd0;
    intervals[1] = 20'd1;
    intervals[2] = 20'hFFFFF;
    intervals[3] = 20'd2;
    intervals[4] = 20'($urandom_range(3, 40));
    intervals[5] = 20'd16;
    intervals[6] = 20'($urandom_range(41, 300));
    for (p = 0; p < 7; p++) begin
      set_interval(intervals[p]);
      big = (p == 3);
      batch.delete();
      s = byte_row('0);
      while (batch.size() < 180) begin
        if (intervals[p] == 0 || intervals[p] > 4096) begin
          s.b = 8'($urandom);
          batch.push_back(s);
        end else begin
          for (k = 0; k < intervals[p]; k++) begin
            s.b = 8'($urandom);
            batch.push_back(s);
          end
          if (big) begin
            nblk = 64;
            big = 1'b0;
          end else if ($urandom_range(0, 9) < 9) begin
            nblk = $urandom_range(0, 3);
          end else begin
            nblk = $urandom_range(4, 31);
          end
          s.b = 8'(nblk);
          batch.push_back(s);
          trim = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(0, nblk * 16);
          for (k = 1; k <= nblk * 16; k++) begin
            if (k < trim) s.b = 8'($urandom);
            else if (k == trim) s.b = 8'($urandom_range(1, 255));
            else s.b = 8'h00;
            batch.push_back(s);
          end
        end
      end
      // sometimes stop mid-section so the next write restarts the counters
      if ($urandom_range(0, 1) == 1)
        repeat ($urandom_range(1, 20)) void'(batch.pop_back());
      foreach (batch[i]) stream_q.push_back(batch[i]);
    end

    wait_drained();
    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
